>>> sv/tdpt_pkg.sv
// Shared types and constants for the trial division prime test core.
package tdpt_pkg;

	// Smallest trial divisor.
	localparam int unsigned FIRST_DIVISOR = 2;

	// Controller to divider.
	typedef struct packed {
		logic start;
	} div_ctl_t;

	// Divider to controller.
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

>>> sv/tdpt_divider.sv
// Bit-serial restoring divider: one quotient bit per clock.
module tdpt_divider #(
	parameter int unsigned VALUE_WIDTH = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tdpt_pkg::div_ctl_t      ctl,
	output tdpt_pkg::div_sts_t      sts,
	input  logic [VALUE_WIDTH-1:0]  dividend,
	input  logic [VALUE_WIDTH-1:0]  divisor,
	output logic [VALUE_WIDTH-1:0]  quotient,
	output logic [VALUE_WIDTH-1:0]  remainder
);
	import tdpt_pkg::*;

	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   ge;

	// trial = remainder shifted left with the next dividend bit
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the last divide step
			done_q <= busy_q && !ctl.start && (cnt_q == CW'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> sv/trial_division_prime_test_core.sv
// Top level of the trial division prime test core.
//
// Usage: a candidate item enters on the req channel (req_valid/req_stall)
// and one result item leaves on the rsp channel (rsp_valid/rsp_stall),
// carrying the echoed value and the prime flag. An item moves on any rising
// edge where valid is high and stall is low.
// Sequence: 0 and 1 go straight to the emit state without a division. Otherwise
// each trial divisor d takes a load, VALUE_WIDTH bit-serial divide steps and
// one decision on the single shared divider. A prime near 2^31 tries about
// 46340 divisors at the default width.
// Throughput: one item at a time; req_stall is high from acceptance until
// the result has been moved into the output register. The output register
// lets the next item be taken while an earlier result still waits.
// Stall: while rsp_stall holds a result, a finished test waits in its emit
// state; nothing is dropped.
// Reset: arst_n clears the controller and the output valid at once; the core
// is ready for an item on the first cycle after release.
module trial_division_prime_test_core #(
	parameter int unsigned VALUE_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   is_prime
);
	import tdpt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] n_q;       // candidate under test
	logic [VALUE_WIDTH-1:0] d_q;       // current trial divisor
	logic                   prime_q;   // verdict waiting to be emitted
	logic                   start_q;
	logic                   rsp_valid_q;
	logic [VALUE_WIDTH-1:0] rsp_value_q;
	logic                   rsp_prime_q;

	div_ctl_t               div_ctl;
	div_sts_t               div_sts;
	logic [VALUE_WIDTH-1:0] quo;
	logic [VALUE_WIDTH-1:0] rem;
	logic                   req_take;
	logic                   out_free;
	logic                   launch;    // start a divide on the next cycle
	logic                   rsp_load;  // verdict moves into the output register

	assign div_ctl.start = start_q;

	tdpt_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.sts       (div_sts),
		.dividend  (n_q),
		.divisor   (d_q),
		.quotient  (quo),
		.remainder (rem)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	// output register can take a result this cycle
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == ST_EMIT) && out_free;
	// first divisor for a new candidate above 1, or next divisor when the
	// current one neither ends the loop nor divides evenly
	assign launch = ((state_q == ST_IDLE) && req_take && (candidate > VALUE_WIDTH'(1))) ||
		((state_q == ST_DIV) && div_sts.done && (d_q <= quo) && (rem != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			n_q         <= '0;
			d_q         <= '0;
			prime_q     <= 1'b0;
			rsp_value_q <= '0;
			rsp_prime_q <= 1'b0;
		end else begin
			start_q <= launch;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						n_q <= candidate;
						d_q <= VALUE_WIDTH'(FIRST_DIVISOR);
						// 0 and 1 are not prime, no division needed
						if (candidate <= VALUE_WIDTH'(1)) begin
							prime_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						// loop ends once d exceeds n / d: no factor found
						if (d_q > quo) begin
							prime_q <= 1'b1;
							state_q <= ST_EMIT;
						end else if (rem == '0) begin
							prime_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							d_q <= d_q + VALUE_WIDTH'(1);
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						rsp_value_q <= n_q;
						rsp_prime_q <= prime_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign tested_value = rsp_value_q;
	assign is_prime     = rsp_prime_q;

endmodule
